@@ rtl/lpfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Length-prefixed frame parser package
// Header layout constants and the result beat type shared by the parser files.
// ----------------------------------------------------------------------------
package lpfp_pkg;

   localparam int HEADER_BYTES = 10;
   localparam int COUNT_W      = 4;
   localparam int LENGTH_W     = 32;

   // header byte positions
   localparam logic [COUNT_W-1:0] LEN_BYTES   = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] ID_POS      = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] STATUS_POS  = COUNT_W'(5);
   localparam logic [COUNT_W-1:0] HEADER_LAST = COUNT_W'(HEADER_BYTES - 1);

   localparam logic [LENGTH_W-1:0] HEADER_LEN = LENGTH_W'(HEADER_BYTES);
   localparam logic [7:0]          BIND_RESPONSE_ID = 8'h81;

   typedef struct packed {
      logic [7:0]  packet_id;
      logic [7:0]  status_code;
      logic [31:0] sequence_number;
      logic [7:0]  data_byte;
      logic        has_data;
      logic        last_of_packet;
      logic        is_bind_response;
   } rsp_payload_type;

endpackage
`default_nettype wire

@@ rtl/lpfp_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
interface lpfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/lpfp_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one tagged body byte or empty-packet marker.
// ----------------------------------------------------------------------------
interface lpfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  packet_id;
   logic [7:0]  status_code;
   logic [31:0] sequence_number;
   logic [7:0]  data_byte;
   logic        has_data;
   logic        last_of_packet;
   logic        is_bind_response;

   modport source (output valid, output packet_id, output status_code,
                   output sequence_number, output data_byte, output has_data,
                   output last_of_packet, output is_bind_response, input ready);
   modport sink   (input valid, input packet_id, input status_code,
                   input sequence_number, input data_byte, input has_data,
                   input last_of_packet, input is_bind_response, output ready);
endinterface
`default_nettype wire

@@ rtl/lpfp_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Length-prefixed frame parser core
// Header collection and body counting state; one byte per step.
// ----------------------------------------------------------------------------
module lpfp_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [7:0]               rx_byte,
   output      logic                     res_valid,
   output      lpfp_pkg::rsp_payload_type res
);

   logic                                  in_body_ff, in_body_in;
   logic [lpfp_pkg::COUNT_W-1:0]          header_count_ff, header_count_in;
   logic [lpfp_pkg::LENGTH_W-1:0]         length_ff, length_in;
   logic [7:0]                            packet_id_ff, packet_id_in;
   logic [7:0]                            status_ff, status_in;
   logic [31:0]                           sequence_ff, sequence_in;
   logic [lpfp_pkg::LENGTH_W-1:0]         remaining_ff, remaining_in;
   logic                                  body_last;

   assign body_last = (remaining_ff <= lpfp_pkg::LENGTH_W'(1));

   always_comb begin
      in_body_in      = in_body_ff;
      header_count_in = header_count_ff;
      length_in       = length_ff;
      packet_id_in    = packet_id_ff;
      status_in       = status_ff;
      sequence_in     = sequence_ff;
      remaining_in    = remaining_ff;
      res_valid       = 1'b0;
      res.packet_id        = packet_id_ff;
      res.status_code      = status_ff;
      res.sequence_number  = sequence_ff;
      res.data_byte        = rx_byte;
      res.has_data         = 1'b1;
      res.last_of_packet   = body_last;
      res.is_bind_response = (packet_id_ff == lpfp_pkg::BIND_RESPONSE_ID);

      if (in_body_ff) begin
         res_valid = 1'b1;
         if (body_last) begin
            in_body_in      = 1'b0;
            remaining_in    = '0;
            header_count_in = '0;
         end else begin
            remaining_in = remaining_ff - lpfp_pkg::LENGTH_W'(1);
         end
      end else begin
         priority if (header_count_ff < lpfp_pkg::LEN_BYTES) begin
            length_in = {length_ff[lpfp_pkg::LENGTH_W-9:0], rx_byte};
         end else if (header_count_ff == lpfp_pkg::ID_POS) begin
            packet_id_in = rx_byte;
         end else if (header_count_ff == lpfp_pkg::STATUS_POS) begin
            status_in = rx_byte;
         end else begin
            sequence_in = {sequence_ff[23:0], rx_byte};
         end

         if (header_count_ff < lpfp_pkg::HEADER_LAST) begin
            header_count_in = header_count_ff + lpfp_pkg::COUNT_W'(1);
         end else begin
            header_count_in = '0;
            // short length: drop the header; exact length: empty-body marker
            if (length_in == lpfp_pkg::HEADER_LEN) begin
               res_valid            = 1'b1;
               res.packet_id        = packet_id_in;
               res.status_code      = status_in;
               res.sequence_number  = sequence_in;
               res.data_byte        = 8'h00;
               res.has_data         = 1'b0;
               res.last_of_packet   = 1'b1;
               res.is_bind_response = (packet_id_in == lpfp_pkg::BIND_RESPONSE_ID);
            end else if (length_in > lpfp_pkg::HEADER_LEN) begin
               remaining_in = length_in - lpfp_pkg::HEADER_LEN;
               in_body_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff      <= 1'b0;
         header_count_ff <= '0;
      end else if (step) begin
         in_body_ff      <= in_body_in;
         header_count_ff <= header_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         length_ff    <= length_in;
         packet_id_ff <= packet_id_in;
         status_ff    <= status_in;
         sequence_ff  <= sequence_in;
         remaining_ff <= remaining_in;
      end
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      header_count_ff <= lpfp_pkg::HEADER_LAST)
      else $error("header count beyond last header byte");

   a_body_count_clear: assert property (@(posedge clock) disable iff (reset)
      in_body_ff |-> (header_count_ff == '0))
      else $error("header count not cleared during body");

   a_body_ends: assert property (@(posedge clock) disable iff (reset)
      (step && in_body_ff && body_last) |=> !in_body_ff)
      else $error("body did not end after last byte");

endmodule
`default_nettype wire

@@ rtl/length_prefixed_frame_parser_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Length-prefixed frame parser
// Splits a byte stream into 10-byte headers and tagged body bytes.
// ----------------------------------------------------------------------------
// A result is registered and appears on rsp_chan in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the input stalls only while a held result
//    beat is not taken by rsp_chan.
// Reset: synchronous, active high; parser returns to header collection and
//    the result register empties.
module length_prefixed_frame_parser_top (
   input  wire logic  clock,
   input  wire logic  reset,
   lpfp_req_if.sink   req_chan,
   lpfp_rsp_if.source rsp_chan
);

   logic                      accept;
   logic                      res_valid;
   lpfp_pkg::rsp_payload_type res;
   logic                      rsp_valid_ff, rsp_valid_in;
   lpfp_pkg::rsp_payload_type rsp_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   lpfp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .rx_byte   (req_chan.rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = res_valid;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the beat until it is taken
   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.packet_id        = rsp_ff.packet_id;
   assign rsp_chan.status_code      = rsp_ff.status_code;
   assign rsp_chan.sequence_number  = rsp_ff.sequence_number;
   assign rsp_chan.data_byte        = rsp_ff.data_byte;
   assign rsp_chan.has_data         = rsp_ff.has_data;
   assign rsp_chan.last_of_packet   = rsp_ff.last_of_packet;
   assign rsp_chan.is_bind_response = rsp_ff.is_bind_response;

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid) |=> rsp_valid_ff)
      else $error("result beat lost");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed frame parser testbench
// Feeds byte streams of headers, bodies, short-length and empty-body frames
// while both channels stall at random. Each result beat is checked against a
// local deframer.
// ----------------------------------------------------------------------------
module tb;
   import lpfp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int CALM_BYTES     = 250;
   localparam int BUSY_BYTES     = 550;
   localparam int HUGE_BODY      = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpfp_req_if req_chan ();
   lpfp_rsp_if rsp_chan ();

   length_prefixed_frame_parser_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bit idle_on;
   int stall_left;
   int error_count;
   int bytes_sent;
   int frames_sent;
   int headers_dropped;
   int beats_checked;
   int quiet_cycles;

   // local deframer state
   bit                  in_payload;
   logic [COUNT_W-1:0]  hdr_pos;
   logic [31:0]         len_shift;
   logic [7:0]          cur_id;
   logic [7:0]          cur_status;
   logic [31:0]         cur_seq;
   logic [31:0]         payload_left;
   rsp_payload_type     beats_due[$];

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic rsp_payload_type tag_beat(input logic [7:0] data, input logic has,
                                                input logic is_final);
      rsp_payload_type beat;
      beat.packet_id        = cur_id;
      beat.status_code      = cur_status;
      beat.sequence_number  = cur_seq;
      beat.data_byte        = data;
      beat.has_data         = has;
      beat.last_of_packet   = is_final;
      beat.is_bind_response = (cur_id == BIND_RESPONSE_ID);
      return beat;
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      bit is_final;
      if (in_payload) begin
         is_final = (payload_left <= 32'd1);
         beats_due.insert(beats_due.size(), tag_beat(b, 1'b1, is_final));
         if (is_final) begin
            payload_left = '0;
            in_payload   = 1'b0;
            hdr_pos      = '0;
         end else begin
            payload_left = payload_left - 32'd1;
         end
         return;
      end
      if (hdr_pos < LEN_BYTES) begin
         len_shift = {len_shift[23:0], b};
      end else if (hdr_pos == ID_POS) begin
         cur_id = b;
      end else if (hdr_pos == STATUS_POS) begin
         cur_status = b;
      end else begin
         cur_seq = {cur_seq[23:0], b};
      end
      if (hdr_pos < HEADER_LAST) begin
         hdr_pos = hdr_pos + 1'b1;
         return;
      end
      hdr_pos = '0;
      // short lengths are dropped without a beat
      if (len_shift == HEADER_LEN) begin
         beats_due.insert(beats_due.size(), tag_beat(8'h00, 1'b0, 1'b1));
      end else if (len_shift > HEADER_LEN) begin
         payload_left = len_shift - HEADER_LEN;
         in_payload   = 1'b1;
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      deframe_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_header(input logic [31:0] len, input logic [7:0] id,
                              input logic [7:0] status, input logic [31:0] seq);
      for (int i = 0; i < 4; i++) send_byte(len[8*(3-i) +: 8]);
      send_byte(id);
      send_byte(status);
      for (int i = 0; i < 4; i++) send_byte(seq[8*(3-i) +: 8]);
      if (len < HEADER_LEN) headers_dropped++;
      else frames_sent++;
   endtask

   task automatic send_random_body(input int n);
      for (int i = 0; i < n; i++) send_byte(8'($urandom()));
   endtask

   task automatic test_short_length();
      send_header(HEADER_LEN - 1, BIND_RESPONSE_ID, 8'h00, 32'h0000_0000);
   endtask

   task automatic test_empty_body();
      send_header(HEADER_LEN, BIND_RESPONSE_ID, 8'h00, 32'hFFFF_FFFF);
   endtask

   task automatic test_body_extremes();
      send_header(HEADER_LEN + 2, 8'h00, 8'hFF, 32'h0000_0000);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   // Mostly well-formed frames, with short-length headers mixed in as noise.
   task automatic test_random_frames(input bit with_idle, input int budget);
      int start;
      int r;
      int body_len;
      logic [7:0] id;
      start   = bytes_sent;
      idle_on = with_idle;
      while (bytes_sent - start < budget) begin
         id = ($urandom_range(0, 4) == 0) ? BIND_RESPONSE_ID : 8'($urandom());
         if ($urandom_range(0, 3) == 0) begin
            send_header(32'($urandom_range(0, HEADER_BYTES - 1)), id, 8'($urandom()),
                        $urandom());
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) body_len = 0;
            else if (r < 85) body_len = $urandom_range(1, 16);
            else body_len = $urandom_range(17, 64);
            send_header(HEADER_LEN + 32'(body_len), id, 8'($urandom()), $urandom());
            send_random_body(body_len);
         end
      end
   endtask

   // Leaves the parser deep inside a body that never ends.
   task automatic test_huge_length();
      idle_on = 1'b1;
      send_header(32'hFFFF_FFFF, 8'($urandom()), 8'($urandom()), $urandom());
      send_random_body(HUGE_BODY);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Result sink: random stalls, mostly short.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
         rsp_chan.ready <= 1'b0;
         stall_left = pick_gap();
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_beats
      rsp_payload_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (beats_due.size() == 0) begin
            $error("result beat with nothing due: id 0x%0h data 0x%0h",
                   rsp_chan.packet_id, rsp_chan.data_byte);
            error_count++;
         end else begin
            want = beats_due.pop_front();
            check_field("packet_id", 32'(want.packet_id), 32'(rsp_chan.packet_id));
            check_field("status_code", 32'(want.status_code), 32'(rsp_chan.status_code));
            check_field("sequence_number", want.sequence_number,
                        rsp_chan.sequence_number);
            check_field("data_byte", 32'(want.data_byte), 32'(rsp_chan.data_byte));
            check_field("has_data", 32'(want.has_data), 32'(rsp_chan.has_data));
            check_field("last_of_packet", 32'(want.last_of_packet),
                        32'(rsp_chan.last_of_packet));
            check_field("is_bind_response", 32'(want.is_bind_response),
                        32'(rsp_chan.is_bind_response));
            beats_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready   = 1'b0;
      idle_on          = 1'b0;
      in_payload       = 1'b0;
      hdr_pos          = '0;
      len_shift        = '0;
      cur_id           = '0;
      cur_status       = '0;
      cur_seq          = '0;
      payload_left     = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_on = 1'b1;
      test_short_length();
      test_empty_body();
      test_body_extremes();
      test_random_frames(1'b0, CALM_BYTES);
      test_random_frames(1'b1, BUSY_BYTES);
      test_huge_length();

      req_chan.valid <= 1'b0;
      while (beats_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d bytes: %0d frames with length >= 10, %0d short headers dropped.",
               bytes_sent, frames_sent, headers_dropped);
      $display("Checked %0d result beats under random stalls on both channels.",
               beats_checked);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
